// ===== design/astk_pkg.sv =====
// ----------------------------------------------------------------------------
// astk_pkg: shared types, constants and functions
// Constants of the probe filter, keypad bands and scan channels, and the record
// passed from the scan core to the output stage.
// ----------------------------------------------------------------------------
package astk_pkg;

  localparam int unsigned AdcW       = 12;
  localparam int unsigned FiltW      = 32;
  localparam int unsigned TenthsW    = 11;
  localparam int unsigned KeyW       = 5;
  localparam int unsigned ChanW      = 2;
  localparam int unsigned PaddrW     = 2;
  localparam int unsigned PdataW     = 32;

  localparam logic [AdcW-1:0] UnplugReset = 12'hEEE;

  localparam logic signed [39:0] FiltOffset = 40'sd3751936;
  localparam logic [10:0]        FiltSlope  = 11'd1490;

  localparam logic [AdcW-1:0] KeyBand0 = 12'd80;
  localparam logic [AdcW-1:0] KeyBand1 = 12'd282;
  localparam logic [AdcW-1:0] KeyBand2 = 12'd574;
  localparam logic [AdcW-1:0] KeyBand3 = 12'd1057;
  localparam logic [AdcW-1:0] KeyBand4 = 12'd2000;

  localparam logic [ChanW-1:0] ChanInternal = 2'd0;
  localparam logic [ChanW-1:0] ChanExternal = 2'd1;
  localparam logic [ChanW-1:0] ChanKeypad   = 2'd2;

  localparam logic [PaddrW-1:0] AddrUnplugThreshold = 2'd0;

  typedef struct packed {
    logic [ChanW-1:0]        start_channel;
    logic signed [FiltW-1:0] filt_internal;
    logic signed [FiltW-1:0] filt_external;
    logic [1:0]              plug_flags;
    logic [AdcW-1:0]         raw_keypad;
  } scan_rec_t;

  function automatic logic signed [FiltW-1:0] filter_update(
    input logic signed [FiltW-1:0] old_val,
    input logic [AdcW-1:0]         raw
  );
    logic signed [39:0] old_ext;
    logic signed [39:0] slope_term;
    logic signed [39:0] acc;
    old_ext    = 40'(old_val);
    slope_term = $signed({17'd0, FiltSlope * {11'd0, raw}});
    acc        = FiltOffset - slope_term + (old_ext <<< 6) - old_ext;
    return acc[FiltW+5:6];
  endfunction

  function automatic logic [TenthsW-1:0] to_tenths(input logic signed [FiltW-1:0] q16);
    logic signed [35:0] prod;
    logic signed [35:0] adj;
    prod = (36'(q16) <<< 3) + (36'(q16) <<< 1);
    adj  = prod[35] ? prod + 36'sd65535 : prod;
    return adj[TenthsW+15:16];
  endfunction

  function automatic logic [KeyW-1:0] key_decode(input logic [AdcW-1:0] v);
    logic [KeyW-1:0] mask;
    priority if (v < KeyBand0) mask = 5'b00001;
    else if (v < KeyBand1)     mask = 5'b00010;
    else if (v < KeyBand2)     mask = 5'b00100;
    else if (v < KeyBand3)     mask = 5'b01000;
    else if (v < KeyBand4)     mask = 5'b10000;
    else                       mask = 5'b00000;
    return mask;
  endfunction

endpackage

// ===== design/astk_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// astk_cfg_regs: configuration register file
// APB-style slave holding the probe unplug threshold.
// ----------------------------------------------------------------------------
module astk_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [astk_pkg::PaddrW-1:0] paddr,
  input  logic [astk_pkg::PdataW-1:0] pwdata,
  output logic [astk_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output logic [astk_pkg::AdcW-1:0]   unplug_threshold_o
);
  import astk_pkg::*;

  logic [AdcW-1:0] thr_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == AddrUnplugThreshold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= UnplugReset;
    end else if (wr_en) begin
      thr_q <= pwdata[AdcW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrUnplugThreshold) begin
      prdata = {{(PdataW-AdcW){1'b0}}, thr_q};
    end
  end

  assign unplug_threshold_o = thr_q;

endmodule

// ===== design/astk_scan_core.sv =====
// ----------------------------------------------------------------------------
// astk_scan_core: scan sequencer and probe filter
// Registers each conversion result, then advances the scan phase, stores raw
// readings and runs the filter update into the record register.
// ----------------------------------------------------------------------------
module astk_scan_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [astk_pkg::AdcW-1:0] adc_value_i,
  input  logic [astk_pkg::AdcW-1:0] unplug_threshold_i,
  output logic                      rec_valid_o,
  input  logic                      rec_ready_i,
  output astk_pkg::scan_rec_t       rec_o
);
  import astk_pkg::*;

  localparam logic [1:0] PhStart    = 2'd0;
  localparam logic [1:0] PhInternal = 2'd1;
  localparam logic [1:0] PhExternal = 2'd2;
  localparam logic [1:0] PhKeypad   = 2'd3;

  logic [AdcW-1:0]         adc_q;
  logic                    in_v_q;
  logic                    rec_v_q;
  scan_rec_t               rec_q;
  logic [1:0]              phase_q, phase_d;
  logic [AdcW-1:0]         raw_int_q, raw_int_d;
  logic [AdcW-1:0]         raw_ext_q, raw_ext_d;
  logic [AdcW-1:0]         raw_key_q, raw_key_d;
  logic signed [FiltW-1:0] filt_int_q, filt_int_d;
  logic signed [FiltW-1:0] filt_ext_q, filt_ext_d;
  logic [1:0]              plug_q, plug_d;
  logic [ChanW-1:0]        start_d;
  logic                    rec_slot_free;
  logic                    advance;
  logic                    in_take;

  assign rec_slot_free = !rec_v_q || rec_ready_i;
  assign advance       = in_v_q && rec_slot_free;
  assign in_stall_o    = in_v_q && !rec_slot_free;
  assign in_take       = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d    = phase_q;
    raw_int_d  = raw_int_q;
    raw_ext_d  = raw_ext_q;
    raw_key_d  = raw_key_q;
    filt_int_d = filt_int_q;
    filt_ext_d = filt_ext_q;
    plug_d     = plug_q;
    start_d    = ChanInternal;
    unique case (phase_q)
      PhStart: begin
        start_d = ChanInternal;
        phase_d = PhInternal;
      end
      PhInternal: begin
        raw_int_d = adc_q;
        start_d   = ChanExternal;
        phase_d   = PhExternal;
      end
      PhExternal: begin
        raw_ext_d = adc_q;
        start_d   = ChanKeypad;
        phase_d   = PhKeypad;
      end
      PhKeypad: begin
        raw_key_d  = adc_q;
        start_d    = ChanInternal;
        phase_d    = PhInternal;
        filt_int_d = filter_update(filt_int_q, raw_int_q);
        filt_ext_d = filter_update(filt_ext_q, raw_ext_q);
        plug_d     = {raw_ext_q <= unplug_threshold_i, raw_int_q <= unplug_threshold_i};
      end
      default: begin
        phase_d = PhStart;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      rec_v_q    <= 1'b0;
      phase_q    <= PhStart;
      raw_int_q  <= '0;
      raw_ext_q  <= '0;
      raw_key_q  <= '0;
      filt_int_q <= '0;
      filt_ext_q <= '0;
      plug_q     <= '0;
    end else begin
      if (in_take) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        rec_v_q    <= 1'b1;
        phase_q    <= phase_d;
        raw_int_q  <= raw_int_d;
        raw_ext_q  <= raw_ext_d;
        raw_key_q  <= raw_key_d;
        filt_int_q <= filt_int_d;
        filt_ext_q <= filt_ext_d;
        plug_q     <= plug_d;
      end else if (rec_ready_i) begin
        rec_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      adc_q <= adc_value_i;
    end
    if (advance) begin
      rec_q.start_channel <= start_d;
      rec_q.filt_internal <= filt_int_d;
      rec_q.filt_external <= filt_ext_d;
      rec_q.plug_flags    <= plug_d;
      rec_q.raw_keypad    <= raw_key_d;
    end
  end

  assign rec_valid_o = rec_v_q;
  assign rec_o       = rec_q;

endmodule

// ===== design/astk_out_stage.sv =====
// ----------------------------------------------------------------------------
// astk_out_stage: result formatting and output register
// Converts filter state to tenths of a degree, decodes the keypad band and
// holds the result item until it is taken.
// ----------------------------------------------------------------------------
module astk_out_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rec_valid_i,
  output logic                         rec_ready_o,
  input  astk_pkg::scan_rec_t          rec_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [astk_pkg::ChanW-1:0]   start_channel_o,
  output logic signed [astk_pkg::TenthsW-1:0] temp_internal_tenths_o,
  output logic signed [astk_pkg::TenthsW-1:0] temp_external_tenths_o,
  output logic                         internal_plugged_o,
  output logic                         external_plugged_o,
  output logic [astk_pkg::KeyW-1:0]    key_mask_o
);
  import astk_pkg::*;

  logic              out_v_q;
  logic              load;
  logic [ChanW-1:0]  chan_q;
  logic [TenthsW-1:0] t_int_q;
  logic [TenthsW-1:0] t_ext_q;
  logic [1:0]        plug_q;
  logic [KeyW-1:0]   key_q;

  assign rec_ready_o = !out_v_q || !out_stall_i;
  assign load        = rec_valid_i && rec_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rec_ready_o) begin
      out_v_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chan_q  <= rec_i.start_channel;
      t_int_q <= to_tenths(rec_i.filt_internal);
      t_ext_q <= to_tenths(rec_i.filt_external);
      plug_q  <= rec_i.plug_flags;
      key_q   <= key_decode(rec_i.raw_keypad);
    end
  end

  assign out_valid_o            = out_v_q;
  assign start_channel_o        = chan_q;
  assign temp_internal_tenths_o = $signed(t_int_q);
  assign temp_external_tenths_o = $signed(t_ext_q);
  assign internal_plugged_o     = plug_q[0];
  assign external_plugged_o     = plug_q[1];
  assign key_mask_o             = key_q;

endmodule

// ===== design/adc_scan_temp_filter_keypad_top.sv =====
// ----------------------------------------------------------------------------
// adc_scan_temp_filter_keypad_top: ADC scan, probe filter and keypad decode
// Round-robin ADC channel sequencing with low-pass filtered probe temperatures,
// probe-plugged detection and a one-hot analog keypad mask.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid_i / in_stall_o   adc_value_i
//  output    out        out_valid_o / out_stall_i start_channel_o, temps, flags, key
//  config    in         psel/penable/pready       paddr, pwdata, prdata
//
// One item is accepted per cycle while in_stall_o is low; each item's result passes
// through the input register, the filter update register and the output register
// before it appears on the outputs.
// The filter update and tenths conversion each sit in their own register stage.
// Reset clears the scan phase, raw readings and filter state, and sets the
// threshold to 3822.
// A stall on the output backs up through the stages and then stalls the input.
// ----------------------------------------------------------------------------
module adc_scan_temp_filter_keypad_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [astk_pkg::AdcW-1:0]    adc_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [astk_pkg::ChanW-1:0]   start_channel_o,
  output logic signed [astk_pkg::TenthsW-1:0] temp_internal_tenths_o,
  output logic signed [astk_pkg::TenthsW-1:0] temp_external_tenths_o,
  output logic                         internal_plugged_o,
  output logic                         external_plugged_o,
  output logic [astk_pkg::KeyW-1:0]    key_mask_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [astk_pkg::PaddrW-1:0]  paddr,
  input  logic [astk_pkg::PdataW-1:0]  pwdata,
  output logic [astk_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import astk_pkg::*;

  logic [AdcW-1:0] unplug_threshold;
  logic            rec_valid;
  logic            rec_ready;
  scan_rec_t       rec;

  astk_cfg_regs u_cfg (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .unplug_threshold_o (unplug_threshold)
  );

  astk_scan_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .adc_value_i        (adc_value_i),
    .unplug_threshold_i (unplug_threshold),
    .rec_valid_o        (rec_valid),
    .rec_ready_i        (rec_ready),
    .rec_o              (rec)
  );

  astk_out_stage u_out (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .rec_valid_i            (rec_valid),
    .rec_ready_o            (rec_ready),
    .rec_i                  (rec),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .start_channel_o        (start_channel_o),
    .temp_internal_tenths_o (temp_internal_tenths_o),
    .temp_external_tenths_o (temp_external_tenths_o),
    .internal_plugged_o     (internal_plugged_o),
    .external_plugged_o     (external_plugged_o),
    .key_mask_o             (key_mask_o)
  );

endmodule
